@@ hdl/sse_pkg.sv @@
// Shared widths, command and register codes, and the popcount helper of the subset enumerator.
package sse_pkg;

    localparam int CMD_W      = 2;
    localparam int IDX_W      = 4;
    localparam int VAL_W      = 16;
    localparam int MASK_W     = 16;
    localparam int SIZE_W     = 5;
    localparam int SUMOUT_W   = 20;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEST    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE_EMPTY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_ENABLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SUM    = 3'd5;

    localparam logic [31:0] POP_M1  = 32'h5555_5555;
    localparam logic [31:0] POP_M2  = 32'h3333_3333;
    localparam logic [31:0] POP_M4  = 32'h0F0F_0F0F;
    localparam logic [31:0] POP_M8  = 32'h00FF_00FF;
    localparam logic [31:0] POP_M16 = 32'h0000_FFFF;

    function automatic logic [5:0] popcount32(input logic [31:0] v);
        logic [31:0] x;
        x = v;
        x = (x & POP_M1) + ((x >> 1) & POP_M1);
        x = (x & POP_M2) + ((x >> 2) & POP_M2);
        x = (x & POP_M4) + ((x >> 4) & POP_M4);
        x = (x & POP_M8) + ((x >> 8) & POP_M8);
        x = (x & POP_M16) + ((x >> 16) & POP_M16);
        return x[5:0];
    endfunction

endpackage

@@ hdl/sse_channels.sv @@
// Valid/ready channel interfaces for commands, results and register writes.
interface sse_in_if;
    logic                         valid;
    logic                         ready;
    logic [sse_pkg::CMD_W-1:0]    cmd;
    logic [sse_pkg::IDX_W-1:0]    item_index;
    logic [sse_pkg::VAL_W-1:0]    item_value;

    modport source (output valid, cmd, item_index, item_value, input ready);
    modport sink   (input valid, cmd, item_index, item_value, output ready);
endinterface

interface sse_out_if;
    logic                          valid;
    logic                          ready;
    logic [sse_pkg::MASK_W-1:0]    subset_mask;
    logic [sse_pkg::SIZE_W-1:0]    subset_size;
    logic [sse_pkg::SUMOUT_W-1:0]  subset_sum;
    logic                          accepted;
    logic                          last_candidate;
    logic                          exhausted;

    modport source (output valid, subset_mask, subset_size, subset_sum, accepted,
                    last_candidate, exhausted, input ready);
    modport sink   (input valid, subset_mask, subset_size, subset_sum, accepted,
                    last_candidate, exhausted, output ready);
endinterface

interface sse_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sse_pkg::CFG_IDX_W-1:0]   index;
    logic [sse_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/sse_sum_tree.sv @@
// Balanced adder tree over N leaves, padded with zeros to a power of two.
module sse_sum_tree #(
    parameter int N = 16,
    parameter int W = 21
) (
    input  logic [N*W-1:0] i_leaves,
    output logic [W-1:0]   o_sum
);

    localparam int P = 1 << $clog2(N);

    logic [W-1:0] node [2*P-1];

    genvar j, k;
    generate
        for (j = 0; j < P; j++) begin : g_leaf
            if (j < N) begin : g_used
                assign node[P-1+j] = i_leaves[j*W +: W];
            end else begin : g_pad
                assign node[P-1+j] = '0;
            end
        end
        for (k = 0; k < P-1; k++) begin : g_add
            assign node[k] = node[2*k+1] + node[2*k+2];
        end
    endgenerate

    assign o_sum = node[0];

endmodule

@@ hdl/subset_sum_enumerator_top.sv @@
// Subset enumerator top: item store, candidate counter, filters and result register.
//
// Usage:
//   i_in carries commands: load writes item_value to slot item_index, restart
//   rewinds the walk to mask 0 or 1 (include_empty), test examines the next
//   candidate and returns exactly one result on o_out. Loads, restarts and
//   the unused code return nothing.
//   i_cfg writes the registers (index 0..5); it is always ready and should
//   only be used while no command is in flight.
//   Each command transfer lands in an input register; for a test, once the
//   output register is free, the mask popcount, the masked adder tree and
//   the filters run and the result is captured in the output register,
//   which drives o_out.valid. One command per cycle is sustained while
//   results are taken; the adder tree and the filters are combinational.
//   When o_out.ready is low the result holds, the input register still
//   drains loads and restarts, and a pending test waits, which then backs
//   up i_in.ready.
//   Reset clears the counter, the done flag, the registers (item_count 1,
//   include_empty 1, others 0) and both valid flags. Item slots are not
//   cleared and must be loaded before a candidate selects them.
module subset_sum_enumerator_top #(
    parameter int SLOT_COUNT = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sse_in_if.sink    i_in,
    sse_out_if.source o_out,
    sse_cfg_if.sink   i_cfg
);

    localparam int CNT_W  = SLOT_COUNT + 1;
    localparam int SUM_W  = VALUE_BITS + $clog2(SLOT_COUNT + 1);
    localparam int CMP_W  = (SUM_W > sse_pkg::SUMOUT_W) ? SUM_W : sse_pkg::SUMOUT_W;
    localparam int MSK_W  = (SLOT_COUNT > sse_pkg::MASK_W) ? SLOT_COUNT : sse_pkg::MASK_W;
    localparam int EXT_W  = (VALUE_BITS > sse_pkg::VAL_W) ? VALUE_BITS : sse_pkg::VAL_W;

    // registers
    logic [sse_pkg::COUNT_W-1:0]  r_item_count;
    logic                         r_incl;
    logic                         r_limit_en;
    logic [sse_pkg::SIZE_W-1:0]   r_size_limit;
    logic                         r_sum_en;
    logic [sse_pkg::SUMOUT_W-1:0] r_target;

    logic                       r_in_valid;
    logic [sse_pkg::CMD_W-1:0]  r_in_cmd;
    logic [sse_pkg::IDX_W-1:0]  r_in_idx;
    logic [sse_pkg::VAL_W-1:0]  r_in_value;

    logic [VALUE_BITS-1:0] r_store [SLOT_COUNT];
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_done;

    logic                         r_out_valid;
    logic [sse_pkg::MASK_W-1:0]   r_out_mask;
    logic [sse_pkg::SIZE_W-1:0]   r_out_size;
    logic [sse_pkg::SUMOUT_W-1:0] r_out_sum;
    logic                         r_out_acc;
    logic                         r_out_last;
    logic                         r_out_exh;

    logic [CNT_W-1:0] n_cnt;
    logic             n_done;

    logic w_out_free, w_adv, w_test, w_load, w_restart;
    logic [EXT_W-1:0]            w_val_ext;
    logic [VALUE_BITS-1:0]       w_value;
    logic [sse_pkg::COUNT_W-1:0] w_n;
    logic                        w_past, w_last, w_exh;
    logic [CNT_W-1:0]            w_stop_m1;
    logic [5:0]                  w_pop;
    logic [sse_pkg::SIZE_W-1:0]  w_size;
    logic [SLOT_COUNT*SUM_W-1:0] w_leaves;
    logic [SUM_W-1:0]            w_sum;
    logic [CMP_W-1:0]            w_sum_ext;
    logic [MSK_W-1:0]            w_mask_ext;
    logic                        w_acc;

    // config port
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= sse_pkg::COUNT_W'(1);
            r_incl       <= 1'b1;
            r_limit_en   <= 1'b0;
            r_size_limit <= '0;
            r_sum_en     <= 1'b0;
            r_target     <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                sse_pkg::CFG_ITEM_COUNT:    r_item_count <= i_cfg.data[sse_pkg::COUNT_W-1:0];
                sse_pkg::CFG_INCLUDE_EMPTY: r_incl       <= i_cfg.data[0];
                sse_pkg::CFG_LIMIT_ENABLE:  r_limit_en   <= i_cfg.data[0];
                sse_pkg::CFG_SIZE_LIMIT:    r_size_limit <= i_cfg.data[sse_pkg::SIZE_W-1:0];
                sse_pkg::CFG_SUM_ENABLE:    r_sum_en     <= i_cfg.data[0];
                sse_pkg::CFG_TARGET_SUM:    r_target     <= i_cfg.data[sse_pkg::SUMOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_adv      = r_in_valid && ((r_in_cmd != sse_pkg::CMD_TEST) || w_out_free);
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_test     = w_adv && (r_in_cmd == sse_pkg::CMD_TEST);
    assign w_load     = w_adv && (r_in_cmd == sse_pkg::CMD_LOAD);
    assign w_restart  = w_adv && (r_in_cmd == sse_pkg::CMD_RESTART);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_cmd   <= i_in.cmd;
            r_in_idx   <= i_in.item_index;
            r_in_value <= i_in.item_value;
        end
    end

    // item store
    assign w_val_ext = EXT_W'(r_in_value);
    assign w_value   = w_val_ext[VALUE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < SLOT_COUNT; e++) begin
            if (w_load && ({1'b0, r_in_idx} == sse_pkg::COUNT_W'(e))) begin
                r_store[e] <= w_value;
            end
        end
    end

    // candidate evaluation
    assign w_n = (r_item_count > sse_pkg::COUNT_W'(SLOT_COUNT)) ?
                 sse_pkg::COUNT_W'(SLOT_COUNT) : r_item_count;
    assign w_past    = (r_cnt >> w_n) != '0;
    assign w_stop_m1 = ~({CNT_W{1'b1}} << w_n);
    assign w_last    = (r_cnt == w_stop_m1);
    assign w_exh     = r_done || w_past;

    assign w_pop  = sse_pkg::popcount32(32'(r_cnt[SLOT_COUNT-1:0]));
    assign w_size = w_pop[sse_pkg::SIZE_W-1:0];

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            w_leaves[i*SUM_W +: SUM_W] = r_cnt[i] ? SUM_W'(r_store[i]) : '0;
        end
    end

    sse_sum_tree #(
        .N (SLOT_COUNT),
        .W (SUM_W)
    ) u_sum_tree (
        .i_leaves (w_leaves),
        .o_sum    (w_sum)
    );

    assign w_sum_ext  = CMP_W'(w_sum);
    assign w_mask_ext = MSK_W'(r_cnt[SLOT_COUNT-1:0]);
    assign w_acc = !(r_limit_en && (w_size > r_size_limit))
                && !(r_sum_en && (w_sum_ext != CMP_W'(r_target)));

    // walk state
    always_comb begin
        n_cnt  = r_cnt;
        n_done = r_done;
        if (w_restart) begin
            n_cnt  = r_incl ? '0 : CNT_W'(1);
            n_done = 1'b0;
        end else if (w_test) begin
            if (w_exh || w_last) begin
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_test) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_test) begin
            if (w_exh) begin
                r_out_mask <= '0;
                r_out_size <= '0;
                r_out_sum  <= '0;
                r_out_acc  <= 1'b0;
                r_out_last <= 1'b0;
                r_out_exh  <= 1'b1;
            end else begin
                r_out_mask <= w_mask_ext[sse_pkg::MASK_W-1:0];
                r_out_size <= w_size;
                r_out_sum  <= w_sum_ext[sse_pkg::SUMOUT_W-1:0];
                r_out_acc  <= w_acc;
                r_out_last <= w_last;
                r_out_exh  <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.subset_mask    = r_out_mask;
    assign o_out.subset_size    = r_out_size;
    assign o_out.subset_sum     = r_out_sum;
    assign o_out.accepted       = r_out_acc;
    assign o_out.last_candidate = r_out_last;
    assign o_out.exhausted      = r_out_exh;

    // checks
    a_exh_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_exh) |-> (r_out_mask == '0) && (r_out_size == '0)
            && (r_out_sum == '0) && !r_out_acc && !r_out_last)
        else $error("exhausted result carries nonzero fields");

    a_last_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_test && !w_exh && w_last) |=> r_done)
        else $error("done flag not set after last candidate");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cnt[CNT_W-1])
        else $error("candidate counter ran past the widest walk");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !w_test)
        else $error("pending result overwritten");

endmodule

@@ dv/testbench.sv @@
// Testbench for the subset enumerator: random command traffic checked against a candidate predictor.
`timescale 1ns / 100ps

module testbench;

    localparam logic [sse_pkg::CMD_W-1:0]     CMD_UNUSED  = 2'd3;
    localparam logic [sse_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [sse_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam int NUM_SLOTS       = 16;
    localparam int ITEM_GOAL       = 1750;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_WALK        = 40;

    typedef struct packed {
        logic [sse_pkg::MASK_W-1:0]   mask;
        logic [sse_pkg::SIZE_W-1:0]   pop;
        logic [sse_pkg::SUMOUT_W-1:0] total;
        logic                         ok;
        logic                         last;
        logic                         done;
    } t_cand_result;

    class t_subset_scoreboard;
        logic [sse_pkg::VAL_W-1:0]     slot_val [NUM_SLOTS];
        logic [sse_pkg::MASK_W:0]      next_mask;
        bit                            walk_done;
        logic [sse_pkg::COUNT_W-1:0]   reg_count;
        bit                            reg_empty;
        bit                            reg_limit_en;
        logic [sse_pkg::SIZE_W-1:0]    reg_size_limit;
        bit                            reg_sum_en;
        logic [sse_pkg::SUMOUT_W-1:0]  reg_target;
        t_cand_result                  expected_q [$];
        int                            mismatches;
        int                            checked;

        function new();
            foreach (slot_val[i]) slot_val[i] = '0;
            next_mask      = '0;
            walk_done      = 1'b0;
            reg_count      = sse_pkg::COUNT_W'(1);
            reg_empty      = 1'b1;
            reg_limit_en   = 1'b0;
            reg_size_limit = '0;
            reg_sum_en     = 1'b0;
            reg_target     = '0;
            mismatches     = 0;
            checked        = 0;
        endfunction

        function void write_reg(logic [sse_pkg::CFG_IDX_W-1:0] idx,
                                logic [sse_pkg::CFG_DATA_W-1:0] d);
            case (idx)
                sse_pkg::CFG_ITEM_COUNT:    reg_count      = d[sse_pkg::COUNT_W-1:0];
                sse_pkg::CFG_INCLUDE_EMPTY: reg_empty      = d[0];
                sse_pkg::CFG_LIMIT_ENABLE:  reg_limit_en   = d[0];
                sse_pkg::CFG_SIZE_LIMIT:    reg_size_limit = d[sse_pkg::SIZE_W-1:0];
                sse_pkg::CFG_SUM_ENABLE:    reg_sum_en     = d[0];
                sse_pkg::CFG_TARGET_SUM:    reg_target     = d[sse_pkg::SUMOUT_W-1:0];
                default: ;
            endcase
        endfunction

        function t_cand_result next_candidate();
            t_cand_result               r;
            int                         n;
            int                         pop;
            logic [sse_pkg::MASK_W+1:0] stop;
            logic [sse_pkg::SUMOUT_W:0] total;
            r = '0;
            n = (reg_count > NUM_SLOTS) ? NUM_SLOTS : reg_count;
            stop = (sse_pkg::MASK_W+2)'(1) << n;
            if (walk_done || next_mask >= stop) begin
                walk_done = 1'b1;
                r.done = 1'b1;
                return r;
            end
            pop = 0;
            total = '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (next_mask[i]) begin
                    pop++;
                    total += slot_val[i];
                end
            end
            r.mask  = next_mask[sse_pkg::MASK_W-1:0];
            r.pop   = sse_pkg::SIZE_W'(pop);
            r.total = total[sse_pkg::SUMOUT_W-1:0];
            r.ok    = !((reg_limit_en && pop > reg_size_limit)
                        || (reg_sum_en && total != reg_target));
            r.last  = (next_mask == stop - 1);
            if (r.last) begin
                walk_done = 1'b1;
            end else begin
                next_mask++;
            end
            return r;
        endfunction

        function void note_command(logic [sse_pkg::CMD_W-1:0] cmd,
                                   logic [sse_pkg::IDX_W-1:0] idx,
                                   logic [sse_pkg::VAL_W-1:0] val);
            case (cmd)
                sse_pkg::CMD_LOAD: slot_val[idx] = val;
                sse_pkg::CMD_RESTART: begin
                    next_mask = reg_empty ? '0 : (sse_pkg::MASK_W+1)'(1);
                    walk_done = 1'b0;
                end
                sse_pkg::CMD_TEST: expected_q.push_back(next_candidate());
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [sse_pkg::SUMOUT_W-1:0] got,
                         logic [sse_pkg::SUMOUT_W-1:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got %h want %h", name, got, want));
            end
        endtask

        task check_result(t_cand_result got);
            t_cand_result want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result, mask %h", got.mask));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            check_field("subset_mask", got.mask, want.mask);
            check_field("subset_size", got.pop, want.pop);
            check_field("subset_sum", got.total, want.total);
            check_field("accepted", got.ok, want.ok);
            check_field("last_candidate", got.last, want.last);
            check_field("exhausted", got.done, want.done);
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sse_in_if  cmd_ch ();
    sse_out_if res_ch ();
    sse_cfg_if cfg_ch ();

    t_subset_scoreboard sb;

    logic [sse_pkg::VAL_W-1:0] gen_vals [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]      loaded;
    int gen_count;
    int items_sent;
    int settings_seen;
    int src_idle_pct;
    int snk_stall_pct;
    int hold_cycles = 0;
    int idle_cycles = 0;

    subset_sum_enumerator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic logic [sse_pkg::VAL_W-1:0] rand_value();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            2:       return sse_pkg::VAL_W'($urandom_range(15));
            default: return sse_pkg::VAL_W'($urandom);
        endcase
    endfunction

    // every call starts and ends at a falling edge
    task automatic send_cmd(logic [sse_pkg::CMD_W-1:0] cmd, logic [sse_pkg::IDX_W-1:0] idx,
                            logic [sse_pkg::VAL_W-1:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.cmd        <= cmd;
        cmd_ch.item_index <= idx;
        cmd_ch.item_value <= val;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
        if (cmd != CMD_UNUSED) items_sent++;
        if (cmd == sse_pkg::CMD_LOAD) begin
            gen_vals[idx] = val;
            loaded[idx] = 1'b1;
        end
    endtask

    // slots selected by the walk must be loaded before a test reaches them
    task automatic send_test();
        for (int i = 0; i < gen_count; i++) begin
            if (!loaded[i]) send_cmd(sse_pkg::CMD_LOAD, sse_pkg::IDX_W'(i), rand_value());
        end
        send_cmd(sse_pkg::CMD_TEST, sse_pkg::IDX_W'($urandom), sse_pkg::VAL_W'($urandom));
    endtask

    task automatic settle();
        cmd_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [sse_pkg::CFG_IDX_W-1:0] idx,
                             logic [sse_pkg::CFG_DATA_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
        if (idx == sse_pkg::CFG_ITEM_COUNT) begin
            gen_count = (d[sse_pkg::COUNT_W-1:0] > NUM_SLOTS) ?
                        NUM_SLOTS : d[sse_pkg::COUNT_W-1:0];
        end
    endtask

    task automatic run_walk(bit squeeze);
        int                             r;
        int                             n_new;
        int                             n_eff;
        int                             walk_len;
        logic [NUM_SLOTS-1:0]           pick;
        logic [sse_pkg::CFG_DATA_W-1:0] d;
        r = $urandom_range(99);
        if (squeeze)     n_new = 16;
        else if (r < 60) n_new = $urandom_range(1, 4);
        else if (r < 70) n_new = 5;
        else if (r < 78) n_new = 0;
        else if (r < 88) n_new = $urandom_range(6, 8);
        else             n_new = $urandom_range(1) ? 31 : $urandom_range(16, 30);
        n_eff = (n_new > NUM_SLOTS) ? NUM_SLOTS : n_new;

        settle();
        for (int i = 0; i < n_eff; i++) begin
            if (!loaded[i] || $urandom_range(3) == 0) begin
                send_cmd(sse_pkg::CMD_LOAD, sse_pkg::IDX_W'(i), rand_value());
            end
        end
        settle();

        d = $urandom_range(2) == 0 ? sse_pkg::CFG_DATA_W'($urandom) : '0;
        d[sse_pkg::COUNT_W-1:0] = sse_pkg::COUNT_W'(n_new);
        cfg_write(sse_pkg::CFG_ITEM_COUNT, d);
        if ($urandom_range(1)) begin
            cfg_write(sse_pkg::CFG_INCLUDE_EMPTY, sse_pkg::CFG_DATA_W'($urandom_range(1)));
        end
        if ($urandom_range(1)) begin
            cfg_write(sse_pkg::CFG_LIMIT_ENABLE, sse_pkg::CFG_DATA_W'($urandom_range(1)));
        end
        if ($urandom_range(1)) begin
            d = $urandom_range(4) == 0 ? sse_pkg::CFG_DATA_W'($urandom_range(31))
                                       : sse_pkg::CFG_DATA_W'($urandom_range(n_eff + 1));
            cfg_write(sse_pkg::CFG_SIZE_LIMIT, d);
        end
        if ($urandom_range(1)) begin
            cfg_write(sse_pkg::CFG_SUM_ENABLE, sse_pkg::CFG_DATA_W'($urandom_range(1)));
        end
        pick = NUM_SLOTS'($urandom) & NUM_SLOTS'((32'd1 << n_eff) - 1);
        d = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (pick[i]) d += gen_vals[i];
        end
        if ($urandom_range(3) == 0) d = sse_pkg::CFG_DATA_W'($urandom);
        cfg_write(sse_pkg::CFG_TARGET_SUM, d);
        if ($urandom_range(19) == 0) begin
            cfg_write($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B,
                      sse_pkg::CFG_DATA_W'($urandom));
        end
        settings_seen++;

        // skipping the restart keeps the old counter against the new item count
        if (squeeze || $urandom_range(6) != 0) begin
            send_cmd(sse_pkg::CMD_RESTART, sse_pkg::IDX_W'($urandom), '0);
        end
        if (squeeze) hold_cycles = HOLD_OFF_CYCLES;
        walk_len = (n_eff <= 5 && !squeeze) ? (1 << n_eff) + 2 : $urandom_range(8, MAX_WALK);
        if (squeeze) walk_len = MAX_WALK;
        for (int t = 0; t < walk_len; t++) begin
            r = $urandom_range(99);
            if (r < 4) begin
                send_cmd(CMD_UNUSED, sse_pkg::IDX_W'($urandom), sse_pkg::VAL_W'($urandom));
            end else if (r < 9) begin
                send_cmd(sse_pkg::CMD_LOAD, sse_pkg::IDX_W'($urandom), rand_value());
            end else if (r < 11) begin
                send_cmd(sse_pkg::CMD_RESTART, sse_pkg::IDX_W'($urandom),
                         sse_pkg::VAL_W'($urandom));
            end
            send_test();
        end
    endtask

    // result side: random stalls plus an occasional long hold-off
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                res_ch.ready <= 1'b0;
                hold_cycles--;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                sb.check_result({res_ch.subset_mask, res_ch.subset_size, res_ch.subset_sum,
                                 res_ch.accepted, res_ch.last_candidate, res_ch.exhausted});
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                sb.note_command(cmd_ch.cmd, cmd_ch.item_index, cmd_ch.item_value);
            end
            if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
            if ((res_ch.valid && res_ch.ready) || (cmd_ch.valid && cmd_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        i_rst_n           = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.cmd        = sse_pkg::CMD_LOAD;
        cmd_ch.item_index = '0;
        cmd_ch.item_value = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = sse_pkg::CFG_ITEM_COUNT;
        cfg_ch.data       = '0;
        loaded            = '0;
        gen_count         = 1;
        items_sent        = 0;
        settings_seen     = 1;
        src_idle_pct      = 0;
        snk_stall_pct     = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: one item, walk from the empty subset, then exhaustion
        send_cmd(sse_pkg::CMD_LOAD, '0, '1);
        send_cmd(sse_pkg::CMD_RESTART, '0, '0);
        repeat (3) send_test();
        send_cmd(CMD_UNUSED, '1, '1);
        send_test();
        send_cmd(sse_pkg::CMD_RESTART, '0, '0);
        send_test();

        // zero items without the empty subset is exhausted at once
        settle();
        cfg_write(sse_pkg::CFG_ITEM_COUNT, '0);
        cfg_write(sse_pkg::CFG_INCLUDE_EMPTY, '0);
        send_cmd(sse_pkg::CMD_RESTART, '0, '0);
        send_test();
        settle();
        cfg_write(sse_pkg::CFG_INCLUDE_EMPTY, sse_pkg::CFG_DATA_W'(1));
        send_cmd(sse_pkg::CMD_RESTART, '0, '0);
        send_test();
        send_test();

        // both filters on, unreachable target
        settle();
        cfg_write(sse_pkg::CFG_ITEM_COUNT, sse_pkg::CFG_DATA_W'(3));
        cfg_write(sse_pkg::CFG_LIMIT_ENABLE, sse_pkg::CFG_DATA_W'(1));
        cfg_write(sse_pkg::CFG_SIZE_LIMIT, sse_pkg::CFG_DATA_W'(1));
        cfg_write(sse_pkg::CFG_SUM_ENABLE, sse_pkg::CFG_DATA_W'(1));
        cfg_write(sse_pkg::CFG_TARGET_SUM, '1);
        settings_seen += 2;
        send_cmd(sse_pkg::CMD_LOAD, 4'd1, '0);
        send_cmd(sse_pkg::CMD_LOAD, 4'd2, '1);
        send_cmd(sse_pkg::CMD_RESTART, '0, '0);
        repeat (5) send_test();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 69; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 69; end
                default: begin src_idle_pct = 24; snk_stall_pct = 24; end
            endcase
            if (p == 0 || p == 2) run_walk(1'b1);
            while (items_sent < ITEM_GOAL * (p + 1) / 4) run_walk(1'b0);
        end
        settle();

        $display("Ran %0d commands over %0d register settings, %0d candidates checked,",
                 items_sent, settings_seen, sb.checked);
        $display("with and without idle gaps, result stalls and a long output hold-off.");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
